>>> design/sacpu_pkg.sv
package sacpu_pkg;

  localparam int unsigned WordBits   = 32;
  localparam int unsigned StackDepth = 1024;
  localparam int unsigned AddrW      = $clog2(StackDepth);
  localparam int unsigned CntW       = AddrW + 1;
  localparam int unsigned IpW        = 16;
  localparam int unsigned StepW      = $clog2(WordBits);

  typedef enum logic [4:0] {
    OP_LDC  = 5'd0,
    OP_LD   = 5'd1,
    OP_ALD  = 5'd2,
    OP_ST   = 5'd3,
    OP_AST  = 5'd4,
    OP_PUSH = 5'd5,
    OP_POP  = 5'd6,
    OP_JMP  = 5'd7,
    OP_JZ   = 5'd8,
    OP_ADD  = 5'd9,
    OP_SUB  = 5'd10,
    OP_MUL  = 5'd11,
    OP_DIV  = 5'd12,
    OP_LT   = 5'd13,
    OP_LE   = 5'd14,
    OP_GT   = 5'd15,
    OP_GE   = 5'd16,
    OP_EQ   = 5'd17,
    OP_NE   = 5'd18,
    OP_IN   = 5'd19,
    OP_OUT  = 5'd20,
    OP_ADDR = 5'd21,
    OP_CALL = 5'd22,
    OP_RET  = 5'd23
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_OP    = 3'd1,
    ST_DIV_ZERO  = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_UNDERFLOW = 3'd4
  } status_e;

  typedef struct packed {
    logic [4:0]         func;
    logic signed [31:0] operand;
    logic signed [31:0] in_value;
  } in_t;

  typedef struct packed {
    logic [IpW-1:0]     next_ip;
    logic signed [31:0] acc_value;
    logic               out_valid;
    logic               done_res;
    logic [2:0]         status;
  } out_t;

  typedef struct packed {
    logic                start;
    logic                is_div;
    logic [WordBits-1:0] a;
    logic [WordBits-1:0] b;
  } md_req_t;

  typedef struct packed {
    logic                done;
    logic [WordBits-1:0] result;
  } md_rsp_t;

endpackage

>>> design/sacpu_muldiv.sv
module sacpu_muldiv (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sacpu_pkg::md_req_t req_i,
  output sacpu_pkg::md_rsp_t rsp_o
);
  import sacpu_pkg::*;

  logic [WordBits-1:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic [StepW-1:0]    step_q, step_d;
  logic                busy_q, busy_d, done_q, done_d, div_q, div_d, neg_q, neg_d;
  logic [WordBits:0]   rsh;
  logic                ge;
  logic [WordBits-1:0] mag_a, mag_b;

  assign mag_a = req_i.a[WordBits-1] ? (~req_i.a + 1'b1) : req_i.a;
  assign mag_b = req_i.b[WordBits-1] ? (~req_i.b + 1'b1) : req_i.b;
  assign rsh   = {z_q, y_q[WordBits-1]};
  assign ge    = rsh >= {1'b0, x_q};

  always_comb begin
    x_d = x_q; y_d = y_q; z_d = z_q;
    step_d = step_q; busy_d = busy_q; div_d = div_q; neg_d = neg_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      div_d  = req_i.is_div;
      neg_d  = req_i.a[WordBits-1] ^ req_i.b[WordBits-1];
      z_d    = '0;
      if (req_i.is_div) begin
        x_d = mag_b;   // divisor
        y_d = mag_a;   // dividend, shifts out while quotient shifts in
      end else begin
        x_d = req_i.a;
        y_d = req_i.b;
      end
    end else if (busy_q) begin
      if (div_q) begin
        z_d = ge ? WordBits'(rsh - {1'b0, x_q}) : rsh[WordBits-1:0];
        y_d = {y_q[WordBits-2:0], ge};
      end else begin
        z_d = y_q[0] ? (z_q + x_q) : z_q;
        x_d = {x_q[WordBits-2:0], 1'b0};
        y_d = {1'b0, y_q[WordBits-1:1]};
      end
      step_d = step_q + 1'b1;
      if (step_q == StepW'(WordBits - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    z_q   <= z_d;
    div_q <= div_d;
    neg_q <= neg_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = div_q ? (neg_q ? (~y_q + 1'b1) : y_q) : z_q;

endmodule

>>> design/sacpu_stack_ram.sv
module sacpu_stack_ram (
  input  logic                            clk_i,
  input  logic                            we_i,
  input  logic [sacpu_pkg::AddrW-1:0]     waddr_i,
  input  logic [sacpu_pkg::WordBits-1:0]  wdata_i,
  input  logic                            re_i,
  input  logic [sacpu_pkg::AddrW-1:0]     raddr_i,
  output logic [sacpu_pkg::WordBits-1:0]  rdata_o
);
  import sacpu_pkg::*;

  logic [WordBits-1:0] mem [StackDepth];
  logic [WordBits-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/stack_accumulator_cpu_execute.sv
// Stack-plus-accumulator execute unit.
// Input channel (in_valid_i/in_ready_o/in_data_i) carries one instruction item:
// opcode, signed operand and the value for IN. Output channel
// (out_valid_o/out_ready_i/out_data_o) returns one item per instruction:
// next pointer, accumulator, OUT flag, done flag and status.
// The config channel (cfg_valid_i/cfg_ready_o/cfg_data_i) writes program_length;
// it is always ready and must only be used while the block is idle.
// Every item passes S_READ and S_EXEC, then S_FIN, which loads the result into
// the output register. A CALL that does not overflow adds S_CALL2 for its second
// stack write, and a MUL or DIV that starts adds S_MDWAIT, running one bit per
// cycle through a shared shift-add / restoring-divide unit. The input is ready
// again as the result becomes valid, and only then: an item is accepted only in
// S_IDLE. The two back-to-back stack reads are issued in S_IDLE and S_READ.
// A new item may be accepted while a result waits; the block then holds in
// its final step until the receiver takes the pending item.
// Reset clears accumulator, frame base, pointer, stack count and
// program_length; stack contents stay undefined, and unwritten entries may be read but their data is never used.
module stack_accumulator_cpu_execute (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  sacpu_pkg::in_t        in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output sacpu_pkg::out_t       out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [15:0]           cfg_data_i
);
  import sacpu_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EXEC, S_CALL2, S_MDWAIT, S_FIN
  } state_e;

  state_e              state_q, state_d;
  logic [WordBits-1:0] acc_q, acc_d, fb_q, fb_d, top_q, top_d;
  logic [IpW-1:0]      ip_q, ip_d, plen_q, plen_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  in_t                 item_q, item_d;
  logic                outv_q, outv_d;
  status_e             stat_q, stat_d;
  logic                ovalid_q, ovalid_d;
  out_t                odata_q, odata_d;

  logic                re, we;
  logic [AddrW-1:0]    raddr, waddr;
  logic [WordBits-1:0] wdata, rdata;
  md_req_t             md_req;
  md_rsp_t             md_rsp;

  op_e                 op;
  logic [WordBits-1:0] idx, imm, cnt_w;
  logic                idx_ok, have;
  logic [IpW-1:0]      ip_inc, ip_jmp;

  assign op     = op_e'(item_q.func);
  assign imm    = item_q.operand;
  assign cnt_w  = WordBits'(cnt_q);
  assign have   = cnt_q != '0;
  assign idx    = (op == OP_LD || op == OP_ST) ? (fb_q - acc_q) : acc_q;
  assign idx_ok = idx < cnt_w;
  assign ip_inc = ip_q + 1'b1;
  assign ip_jmp = ip_q + imm[IpW-1:0];

  sacpu_stack_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  sacpu_muldiv u_md (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  assign in_ready_o  = state_q == S_IDLE;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

  always_comb begin
    state_d = state_q;
    acc_d = acc_q; fb_d = fb_q; ip_d = ip_q; cnt_d = cnt_q;
    plen_d = plen_q; top_d = top_q; item_d = item_q;
    outv_d = outv_q; stat_d = stat_q;
    ovalid_d = ovalid_q; odata_d = odata_q;
    re = 1'b0; raddr = AddrW'(cnt_q - 1'b1);
    we = 1'b0; waddr = cnt_q[AddrW-1:0]; wdata = top_q;
    md_req = '{start: 1'b0, is_div: op == OP_DIV, a: top_q, b: acc_q};

    if (cfg_valid_i) begin
      plen_d = cfg_data_i;
    end
    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          re      = 1'b1;     // fetch stack top
          state_d = S_READ;
        end
      end
      S_READ: begin
        top_d = rdata;
        re    = 1'b1;
        raddr = (op == OP_RET) ? AddrW'(cnt_q - 2'd2) : idx[AddrW-1:0];
        state_d = S_EXEC;
      end
      S_EXEC: begin
        stat_d  = ST_OK;
        outv_d  = 1'b0;
        ip_d    = ip_inc;
        state_d = S_FIN;
        case (op)
          OP_LDC: acc_d = imm;
          OP_LD, OP_ALD: begin
            if (!idx_ok) stat_d = ST_UNDERFLOW;
            else acc_d = rdata;
          end
          OP_ST, OP_AST: begin
            if (!idx_ok) begin
              stat_d = ST_UNDERFLOW;
            end else begin
              we    = 1'b1;
              waddr = idx[AddrW-1:0];
            end
          end
          OP_PUSH: begin
            if (cnt_q >= CntW'(StackDepth)) begin
              stat_d = ST_OVERFLOW;
            end else begin
              we    = 1'b1;
              wdata = acc_q;
              cnt_d = cnt_q + 1'b1;
            end
          end
          OP_POP: begin
            if (!have) stat_d = ST_UNDERFLOW;
            else cnt_d = cnt_q - 1'b1;
          end
          OP_JMP: ip_d = ip_jmp;
          OP_JZ: if (acc_q == '0) ip_d = ip_jmp;
          OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LT, OP_LE, OP_GT, OP_GE, OP_EQ,
          OP_NE: begin
            if (!have) begin
              stat_d = ST_UNDERFLOW;
            end else begin
              case (op)
                OP_ADD: acc_d = top_q + acc_q;
                OP_SUB: acc_d = top_q - acc_q;
                OP_MUL: begin
                  md_req.start = 1'b1;
                  state_d      = S_MDWAIT;
                end
                OP_DIV: begin
                  if (acc_q == '0) begin
                    stat_d = ST_DIV_ZERO;
                  end else begin
                    md_req.start = 1'b1;
                    state_d      = S_MDWAIT;
                  end
                end
                OP_LT: acc_d = WordBits'($signed(top_q) < $signed(acc_q));
                OP_LE: acc_d = WordBits'($signed(top_q) <= $signed(acc_q));
                OP_GT: acc_d = WordBits'($signed(top_q) > $signed(acc_q));
                OP_GE: acc_d = WordBits'($signed(top_q) >= $signed(acc_q));
                OP_EQ: acc_d = WordBits'(top_q == acc_q);
                default: acc_d = WordBits'(top_q != acc_q);
              endcase
            end
          end
          OP_IN:   acc_d = item_q.in_value;
          OP_OUT:  outv_d = 1'b1;
          OP_ADDR: acc_d = cnt_w - imm;
          OP_CALL: begin
            if (cnt_q > CntW'(StackDepth - 2)) begin
              stat_d = ST_OVERFLOW;
            end else begin
              we      = 1'b1;
              wdata   = fb_q;
              fb_d    = cnt_w - 1'b1;
              cnt_d   = cnt_q + 1'b1;
              ip_d    = ip_q;     // old pointer is pushed next
              state_d = S_CALL2;
            end
          end
          OP_RET: begin
            if (cnt_q < CntW'(2)) begin
              stat_d = ST_UNDERFLOW;
            end else begin
              ip_d  = top_q[IpW-1:0] + 1'b1;
              fb_d  = rdata;
              cnt_d = cnt_q - 2'd2;
            end
          end
          default: stat_d = ST_BAD_OP;
        endcase
      end
      S_CALL2: begin
        we      = 1'b1;
        wdata   = WordBits'(ip_q);
        cnt_d   = cnt_q + 1'b1;
        ip_d    = ip_jmp;
        state_d = S_FIN;
      end
      S_MDWAIT: begin
        if (md_rsp.done) begin
          acc_d   = md_rsp.result;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        // hold until the previous item has left the output register
        if (!ovalid_q || out_ready_i) begin
          ovalid_d          = 1'b1;
          odata_d.next_ip   = ip_q;
          odata_d.acc_value = acc_q;
          odata_d.out_valid = outv_q;
          odata_d.done_res  = ip_q >= plen_q;
          odata_d.status    = stat_q;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      acc_q    <= '0;
      fb_q     <= '0;
      ip_q     <= '0;
      cnt_q    <= '0;
      plen_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      acc_q    <= acc_d;
      fb_q     <= fb_d;
      ip_q     <= ip_d;
      cnt_q    <= cnt_d;
      plen_q   <= plen_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q   <= top_d;
    item_q  <= item_d;
    outv_q  <= outv_d;
    stat_q  <= stat_d;
    odata_q <= odata_d;
  end

endmodule

>>> design/sacpu_checker.sv
module sacpu_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input sacpu_pkg::in_t        in_data_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input sacpu_pkg::out_t       out_data_o,
  input logic                  cfg_valid_i,
  input logic                  cfg_ready_o,
  input logic [15:0]           cfg_data_i
);
  import sacpu_pkg::*;

  // an accepted item occupies the block for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after accept");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output item dropped or changed while stalled");

  a_fault_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |-> !out_data_o.out_valid)
    else $error("OUT flagged on a faulting item");

  a_no_result_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared one cycle after accept");

endmodule

bind stack_accumulator_cpu_execute sacpu_checker u_sacpu_checker (.*);
